// ----- hw/rtl/ptcp_pkg.sv -----
// Shared constants and types for the point-to-triangle closest point pipeline.
`timescale 1ns / 1ps
package ptcp_pkg;
	localparam int MUL_CH  = 32;  // partial product chunk width
	localparam int MUL_LAT = 3;   // multiplier pipeline depth
	localparam int SBITS   = 24;  // fraction bits of the s and t parameters

	localparam logic [SBITS:0] FRAC_ONE = {1'b1, {SBITS{1'b0}}};

	typedef enum logic [1:0] {
		PM_ZERO = 2'd0,
		PM_DIV  = 2'd1,
		PM_OMS  = 2'd2
	} pmode_t;

	typedef struct packed {
		logic   deg;
		pmode_t smode;
		pmode_t tmode;
	} sel_t;
endpackage

// ----- hw/rtl/point_triangle_closest_point.sv -----
// Top level: closest point on a 3-D triangle and distance, fully pipelined.
//
// Input channel (in_valid/in_ready) takes a query point and three vertices,
// signed fixed point, one item per cycle. Output channel (out_valid/out_ready)
// returns the closest point on the triangle, the rounded-down distance and a
// degenerate flag, one result per item, in order.
// The pipeline runs through the dot product and product stages, two 25-stage
// fraction dividers, the interpolation and squaring multipliers, and a square
// root of COORD_BITS + 1 stages.
// Throughput is one item per cycle while the output is not stalled.
// The whole pipeline advances on one enable. When a result waits at the output
// and out_ready is low, every stage holds and in_ready drops; nothing is lost
// or repeated. in_ready is high whenever the output is empty or being taken.
// Reset clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module point_triangle_closest_point #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] query_z,
	input  logic signed [COORD_BITS-1:0] vert0_x,
	input  logic signed [COORD_BITS-1:0] vert0_y,
	input  logic signed [COORD_BITS-1:0] vert0_z,
	input  logic signed [COORD_BITS-1:0] vert1_x,
	input  logic signed [COORD_BITS-1:0] vert1_y,
	input  logic signed [COORD_BITS-1:0] vert1_z,
	input  logic signed [COORD_BITS-1:0] vert2_x,
	input  logic signed [COORD_BITS-1:0] vert2_y,
	input  logic signed [COORD_BITS-1:0] vert2_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] closest_x,
	output logic signed [COORD_BITS-1:0] closest_y,
	output logic signed [COORD_BITS-1:0] closest_z,
	output logic [COORD_BITS:0]          distance,
	output logic                         degenerate
);
	import ptcp_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int VW   = CW + 1;
	localparam int DOTW = 2 * VW + 2;
	localparam int PW   = 2 * DOTW + 2;
	localparam int EW   = DOTW + 2;
	localparam int SQW  = 2 * VW + 2;
	localparam int RW   = CW + 1;
	localparam int FW   = SBITS + 1;
	localparam int LW   = VW + SBITS + 3;
	localparam int ML   = MUL_LAT;
	localparam int DL   = SBITS + 1;
	localparam int T4   = 4 + 2 * ML;
	localparam int T5   = T4 + DL + 1;
	localparam int T6   = T5 + ML + 1;
	localparam int T7   = T6 + 1;
	localparam int T8   = T7 + ML + 1;
	localparam int LAT  = T8 + RW;
	localparam int SELW = $bits(sel_t);

	localparam int DA = 0;
	localparam int DB = 1;
	localparam int DC = 2;
	localparam int DD = 3;
	localparam int DE = 4;

	localparam logic [LW-1:0] HALF = LW'(1) << (SBITS - 1);

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Stage 1: edge vectors and offset
	logic signed [CW-1:0] q_in [3], p0_in [3], p1_in [3], p2_in [3];
	logic signed [VW-1:0] v0_s1 [3], v1_s1 [3], l_s1 [3];
	logic signed [CW-1:0] a0_s1 [3], q_s1 [3];

	always_comb begin
		q_in[0]  = query_x;  q_in[1]  = query_y;  q_in[2]  = query_z;
		p0_in[0] = vert0_x;  p0_in[1] = vert0_y;  p0_in[2] = vert0_z;
		p1_in[0] = vert1_x;  p1_in[1] = vert1_y;  p1_in[2] = vert1_z;
		p2_in[0] = vert2_x;  p2_in[1] = vert2_y;  p2_in[2] = vert2_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v0_s1[i] <= VW'(p1_in[i]) - VW'(p0_in[i]);
				v1_s1[i] <= VW'(p2_in[i]) - VW'(p0_in[i]);
				l_s1[i]  <= VW'(p0_in[i]) - VW'(q_in[i]);
				a0_s1[i] <= p0_in[i];
				q_s1[i]  <= q_in[i];
			end
		end
	end

	// Dot products a, b, c, d, e
	logic signed [VW-1:0]   dop_a [15], dop_b [15];
	logic signed [2*VW-1:0] dprod [15];
	logic signed [DOTW-1:0] dot_s2 [5];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dop_a[i]      = v0_s1[i];  dop_b[i]      = v0_s1[i];
			dop_a[3 + i]  = v0_s1[i];  dop_b[3 + i]  = v1_s1[i];
			dop_a[6 + i]  = v1_s1[i];  dop_b[6 + i]  = v1_s1[i];
			dop_a[9 + i]  = l_s1[i];   dop_b[9 + i]  = v0_s1[i];
			dop_a[12 + i] = l_s1[i];   dop_b[12 + i] = v1_s1[i];
		end
	end

	for (genvar g = 0; g < 15; g++) begin : g_dmul
		ptcp_mul #(.AW(VW), .BW(VW)) u_mul (
			.clk(clk), .en(en), .a(dop_a[g]), .b(dop_b[g]), .p(dprod[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 5; k++) begin
				dot_s2[k] <= DOTW'(dprod[3*k]) + DOTW'(dprod[3*k + 1]) + DOTW'(dprod[3*k + 2]);
			end
		end
	end

	// det, sn, tn products
	logic signed [DOTW-1:0]   pop_a [6], pop_b [6];
	logic signed [2*DOTW-1:0] pprod [6];
	logic signed [DOTW-1:0]   dotd [5];

	always_comb begin
		pop_a[0] = dot_s2[DA]; pop_b[0] = dot_s2[DC];
		pop_a[1] = dot_s2[DB]; pop_b[1] = dot_s2[DB];
		pop_a[2] = dot_s2[DB]; pop_b[2] = dot_s2[DE];
		pop_a[3] = dot_s2[DC]; pop_b[3] = dot_s2[DD];
		pop_a[4] = dot_s2[DB]; pop_b[4] = dot_s2[DD];
		pop_a[5] = dot_s2[DA]; pop_b[5] = dot_s2[DE];
	end

	for (genvar g = 0; g < 6; g++) begin : g_pmul
		ptcp_mul #(.AW(DOTW), .BW(DOTW)) u_mul (
			.clk(clk), .en(en), .a(pop_a[g]), .b(pop_b[g]), .p(pprod[g])
		);
	end

	for (genvar g = 0; g < 5; g++) begin : g_dotd
		ptcp_dly #(.W(DOTW), .N(ML)) u_dly (
			.clk(clk), .en(en), .d(dot_s2[g]), .q(dotd[g])
		);
	end

	// Stage 3: numerators and edge terms
	logic signed [PW-1:0] det_s3, sn_s3, tn_s3;
	logic signed [EW-1:0] a_s3, c_s3, negd_s3, nege_s3, deno_s3, edn_s3;
	logic                 lt01_s3, bead_s3, dneg_s3, eneg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3  <= PW'(pprod[0]) - PW'(pprod[1]);
			sn_s3   <= PW'(pprod[2]) - PW'(pprod[3]);
			tn_s3   <= PW'(pprod[4]) - PW'(pprod[5]);
			a_s3    <= EW'(dotd[DA]);
			c_s3    <= EW'(dotd[DC]);
			negd_s3 <= -EW'(dotd[DD]);
			nege_s3 <= -EW'(dotd[DE]);
			deno_s3 <= EW'(dotd[DA]) + EW'(dotd[DC]) - EW'(dotd[DB]) - EW'(dotd[DB]);
			edn_s3  <= EW'(dotd[DC]) + EW'(dotd[DE]) - EW'(dotd[DB]) - EW'(dotd[DD]);
			lt01_s3 <= (EW'(dotd[DB]) + EW'(dotd[DD])) < (EW'(dotd[DC]) + EW'(dotd[DE]));
			bead_s3 <= (EW'(dotd[DB]) + EW'(dotd[DE])) < (EW'(dotd[DA]) + EW'(dotd[DD]));
			dneg_s3 <= dotd[DD][DOTW-1];
			eneg_s3 <= dotd[DE][DOTW-1];
		end
	end

	// Stage 4: region select and divider operands
	logic signed [PW:0] snt;
	logic               in_r;
	sel_t               sel_c, sel_s4;
	logic [PW-1:0]      ns_c, ds_c, nt_c, dt_c;
	logic [PW-1:0]      ns_s4, ds_s4, nt_s4, dt_s4;

	assign snt  = (PW+1)'(sn_s3) + (PW+1)'(tn_s3);
	assign in_r = snt < (PW+1)'(det_s3);

	always_comb begin
		sel_c.deg   = 1'b0;
		sel_c.smode = PM_ZERO;
		sel_c.tmode = PM_ZERO;
		ns_c = '0;
		ds_c = '0;
		nt_c = '0;
		dt_c = '0;
		if (det_s3 == '0) begin
			sel_c.deg = 1'b1;
		end else if (in_r) begin
			if (sn_s3[PW-1]) begin
				if (tn_s3[PW-1] && dneg_s3) begin
					sel_c.smode = PM_DIV;
					ns_c = PW'(negd_s3);
					ds_c = PW'(a_s3);
				end else begin
					sel_c.tmode = eneg_s3 ? PM_DIV : PM_ZERO;
					nt_c = PW'(nege_s3);
					dt_c = PW'(c_s3);
				end
			end else if (tn_s3[PW-1]) begin
				sel_c.smode = dneg_s3 ? PM_DIV : PM_ZERO;
				ns_c = PW'(negd_s3);
				ds_c = PW'(a_s3);
			end else begin
				sel_c.smode = PM_DIV;
				sel_c.tmode = PM_DIV;
				ns_c = sn_s3;
				ds_c = det_s3;
				nt_c = tn_s3;
				dt_c = det_s3;
			end
		end else if (sn_s3[PW-1]) begin
			if (lt01_s3) begin
				sel_c.smode = PM_DIV;
				sel_c.tmode = PM_OMS;
				ns_c = PW'(edn_s3);
				ds_c = PW'(deno_s3);
			end else begin
				sel_c.tmode = eneg_s3 ? PM_DIV : PM_ZERO;
				nt_c = PW'(nege_s3);
				dt_c = PW'(c_s3);
			end
		end else if (tn_s3[PW-1]) begin
			if (bead_s3) begin
				sel_c.smode = (edn_s3 > 0) ? PM_DIV : PM_ZERO;
				sel_c.tmode = PM_OMS;
				ns_c = PW'(edn_s3);
				ds_c = PW'(deno_s3);
			end else begin
				sel_c.smode = dneg_s3 ? PM_DIV : PM_ZERO;
				ns_c = PW'(negd_s3);
				ds_c = PW'(a_s3);
			end
		end else begin
			sel_c.smode = (edn_s3 > 0) ? PM_DIV : PM_ZERO;
			sel_c.tmode = PM_OMS;
			ns_c = PW'(edn_s3);
			ds_c = PW'(deno_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s4 <= sel_c;
			ns_s4  <= ns_c;
			ds_s4  <= ds_c;
			nt_s4  <= nt_c;
			dt_s4  <= dt_c;
		end
	end

	// Fraction dividers
	logic [FW-1:0]   qs, qt;
	logic [SELW-1:0] sel_dv, sel_ov;
	sel_t            sel_d, sel_o;

	ptcp_div #(.DW(PW)) u_sdiv (.clk(clk), .en(en), .num(ns_s4), .den(ds_s4), .quo(qs));
	ptcp_div #(.DW(PW)) u_tdiv (.clk(clk), .en(en), .num(nt_s4), .den(dt_s4), .quo(qt));

	ptcp_dly #(.W(SELW), .N(DL)) u_seld (.clk(clk), .en(en), .d(sel_s4), .q(sel_dv));
	assign sel_d = sel_t'(sel_dv);

	// Stage 5: clamped s and t
	logic [FW-1:0] s_c, t_c, s_s5, t_s5;

	always_comb begin
		s_c = (sel_d.smode == PM_DIV) ? qs : '0;
		case (sel_d.tmode)
			PM_DIV:  t_c = qt;
			PM_OMS:  t_c = FRAC_ONE - s_c;
			default: t_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5 <= s_c;
			t_s5 <= t_c;
		end
	end

	// Interpolation products
	logic signed [VW-1:0]    v0d [3], v1d [3];
	logic signed [CW-1:0]    a0d [3], qd [3];
	logic signed [FW:0]      s_op, t_op;
	logic signed [VW+FW:0]   lprod [6];

	assign s_op = {1'b0, s_s5};
	assign t_op = {1'b0, t_s5};

	for (genvar i = 0; i < 3; i++) begin : g_lerp
		ptcp_dly #(.W(VW), .N(T5 - 1)) u_v0d (.clk(clk), .en(en), .d(v0_s1[i]), .q(v0d[i]));
		ptcp_dly #(.W(VW), .N(T5 - 1)) u_v1d (.clk(clk), .en(en), .d(v1_s1[i]), .q(v1d[i]));
		ptcp_dly #(.W(CW), .N(T5 + ML - 1)) u_a0d (
			.clk(clk), .en(en), .d(a0_s1[i]), .q(a0d[i])
		);
		ptcp_dly #(.W(CW), .N(T6 - 1)) u_qd (.clk(clk), .en(en), .d(q_s1[i]), .q(qd[i]));
		ptcp_mul #(.AW(VW), .BW(FW + 1)) u_smul (
			.clk(clk), .en(en), .a(v0d[i]), .b(s_op), .p(lprod[i])
		);
		ptcp_mul #(.AW(VW), .BW(FW + 1)) u_tmul (
			.clk(clk), .en(en), .a(v1d[i]), .b(t_op), .p(lprod[3 + i])
		);
	end

	// Stage 6: rounded closest point; stage 7: offsets to the query
	logic [LW-1:0]        lacc [3];
	logic signed [CW-1:0] px_s6 [3];
	logic signed [VW-1:0] dx_s7 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lacc[i] = LW'(lprod[i]) + LW'(lprod[3 + i]) + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				px_s6[i] <= a0d[i] + lacc[i][SBITS +: CW];
				dx_s7[i] <= VW'(qd[i]) - VW'(px_s6[i]);
			end
		end
	end

	// Squared distance and root
	logic signed [2*VW-1:0] sqp [3];
	logic [SQW-1:0]         ssq_s8;
	logic signed [CW-1:0]   pxo [3];

	for (genvar i = 0; i < 3; i++) begin : g_sq
		ptcp_mul #(.AW(VW), .BW(VW)) u_mul (
			.clk(clk), .en(en), .a(dx_s7[i]), .b(dx_s7[i]), .p(sqp[i])
		);
		ptcp_dly #(.W(CW), .N(LAT - T6)) u_pxd (.clk(clk), .en(en), .d(px_s6[i]), .q(pxo[i]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ssq_s8 <= SQW'(sqp[0]) + SQW'(sqp[1]) + SQW'(sqp[2]);
		end
	end

	ptcp_sqrt #(.VW(SQW), .RW(RW)) u_sqrt (.clk(clk), .en(en), .val(ssq_s8), .root(distance));

	ptcp_dly #(.W(SELW), .N(LAT - T4 - DL)) u_selo (
		.clk(clk), .en(en), .d(sel_dv), .q(sel_ov)
	);
	assign sel_o = sel_t'(sel_ov);

	assign closest_x  = pxo[0];
	assign closest_y  = pxo[1];
	assign closest_z  = pxo[2];
	assign degenerate = sel_o.deg;

	// Input side stalls only behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a held result");

	// A held result freezes every stage.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(vld_q))
		else $error("pipeline moved during output stall");

	// Clamped parameters never leave the triangle.
	a_st_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[T5-1] |-> (({1'b0, s_s5} + {1'b0, t_s5}) <= {1'b0, FRAC_ONE}))
		else $error("s + t exceeds one");
endmodule

// ----- hw/rtl/ptcp_mul.sv -----
// Pipelined signed multiplier built from registered chunk partial products.
`timescale 1ns / 1ps
module ptcp_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	import ptcp_pkg::*;

	localparam int NA  = (AW + MUL_CH - 1) / MUL_CH;
	localparam int NB  = (BW + MUL_CH - 1) / MUL_CH;
	localparam int AX  = NA * MUL_CH;
	localparam int BX  = NB * MUL_CH;
	localparam int SW  = AX + BX;
	localparam int PWD = AW + BW;

	logic [AW-1:0] abs_a;
	logic [BW-1:0] abs_b;
	logic [AX-1:0] ma_s1;
	logic [BX-1:0] mb_s1;
	logic          neg_s1, neg_s2;
	logic [2*MUL_CH-1:0] pp_s2 [NA][NB];
	logic [SW-1:0] sum;
	logic signed [PWD-1:0] p_s3;

	assign abs_a = a[AW-1] ? (~a + 1'b1) : a;
	assign abs_b = b[BW-1] ? (~b + 1'b1) : b;

	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (SW'(pp_s2[i][j]) << ((i + j) * MUL_CH));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= AX'(abs_a);
			mb_s1  <= BX'(abs_b);
			neg_s1 <= a[AW-1] ^ b[BW-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= ma_s1[i*MUL_CH +: MUL_CH] * mb_s1[j*MUL_CH +: MUL_CH];
				end
			end
			neg_s2 <= neg_s1;
			p_s3   <= neg_s2 ? -sum[PWD-1:0] : sum[PWD-1:0];
		end
	end

	assign p = p_s3;
endmodule

// ----- hw/rtl/ptcp_dly.sv -----
// Fixed-length delay line that advances with the pipeline enable.
`timescale 1ns / 1ps
module ptcp_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int k = 1; k < N; k++) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	assign q = tap_q[N-1];
endmodule

// ----- hw/rtl/ptcp_div.sv -----
// Pipelined restoring divider giving a saturating unsigned fraction.
`timescale 1ns / 1ps
module ptcp_div #(
	parameter int DW = 138
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [DW-1:0]               num,
	input  logic [DW-1:0]               den,
	output logic [ptcp_pkg::SBITS:0]    quo
);
	import ptcp_pkg::*;

	logic [DW-1:0]    rem_s [SBITS+1];
	logic [DW-1:0]    den_s [SBITS+1];
	logic [SBITS-1:0] q_s   [SBITS+1];
	logic             sat_s [SBITS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			// saturate on zero divisor or quotient of one or more
			sat_s[0] <= (den == '0) || (num >= den);
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= SBITS; k++) begin : g_step
		logic [DW:0] dbl;
		logic        ge;
		assign dbl = {rem_s[k-1], 1'b0};
		assign ge  = dbl >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(dbl - {1'b0, den_s[k-1]}) : DW'(dbl);
				den_s[k] <= den_s[k-1];
				q_s[k]   <= {q_s[k-1][SBITS-2:0], ge};
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign quo = sat_s[SBITS] ? FRAC_ONE : {1'b0, q_s[SBITS]};
endmodule

// ----- hw/rtl/ptcp_sqrt.sv -----
// Pipelined bit-by-bit integer square root, one result bit per stage.
`timescale 1ns / 1ps
module ptcp_sqrt #(
	parameter int VW = 68,
	parameter int RW = 33
) (
	input  logic          clk,
	input  logic          en,
	input  logic [VW-1:0] val,
	output logic [RW-1:0] root
);
	logic [VW-1:0] rem_s [RW];
	logic [RW-1:0] r_s   [RW];

	for (genvar i = 0; i < RW; i++) begin : g_bit
		localparam int K = RW - 1 - i;
		logic [VW-1:0] prem;
		logic [RW-1:0] pr;
		logic [VW:0]   trial;
		logic          ge;
		if (i == 0) begin : g_first
			assign prem = val;
			assign pr   = '0;
		end else begin : g_next
			assign prem = rem_s[i-1];
			assign pr   = r_s[i-1];
		end
		// (r + 2^K)^2 - r^2, with r holding no bits below K
		assign trial = ((VW+1)'(pr) << (K + 1)) + ((VW+1)'(1) << (2 * K));
		assign ge    = {1'b0, prem} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? VW'({1'b0, prem} - trial) : prem;
				r_s[i]   <= ge ? (pr | (RW'(1) << K)) : pr;
			end
		end
	end

	assign root = r_s[RW-1];
endmodule
